@@ hw/rtl/integer_text_field_parser_core_defines.svh @@
// Assertion macros shared by the parser RTL.
// Both macros expect i_clk in the enclosing module; ITFP_ASSERT also expects i_rst_n.
`ifndef INTEGER_TEXT_FIELD_PARSER_CORE_DEFINES_SVH
`define INTEGER_TEXT_FIELD_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define ITFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define ITFP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`else

`define ITFP_ASSERT(lbl, prop, msg)
`define ITFP_ASSERT_RST(lbl, prop, msg)

`endif

`endif

@@ hw/rtl/itfp_pkg.sv @@
package itfp_pkg;

    // Default accumulator width and queue depth.
    localparam int VALUE_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIX_MODE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIGN_ALLOWED = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH_GIVEN  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_WIDTH    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_RESULT = 3'd4;

    // Character codes used by the classifier.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    // Radix selection; the codes match the radix_mode register.
    typedef enum logic [1:0] {
        RADIX_AUTO = 2'd0,
        RADIX_OCT  = 2'd1,
        RADIX_DEC  = 2'd2,
        RADIX_HEX  = 2'd3
    } t_radix;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_CONVERTED   = 2'd0,
        ST_NO_DIGITS   = 2'd1,
        ST_EMPTY_INPUT = 2'd2,
        ST_UNUSED      = 2'd3
    } t_status;

    // Parse phase of the back end.
    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_ZERO   = 2'd1,
        PH_PREFIX = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    // What the back end does with one classified character.
    typedef enum logic [2:0] {
        ACT_EMPTY = 3'd0,
        ACT_SPACE = 3'd1,
        ACT_SIGN  = 3'd2,
        ACT_ZERO  = 3'd3,
        ACT_X     = 3'd4,
        ACT_DIGIT = 3'd5,
        ACT_END   = 3'd6
    } t_act;

    // Input word.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_char_in;

    // Result word.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [15:0] chars_consumed;
        logic        char_taken;
    } t_result;

    // Classified character handed from the front to the back.
    typedef struct packed {
        logic       eof;
        logic       is_space;
        logic       is_plus;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       digit_valid;
        logic [5:0] digit_val;
    } t_cls;

    // Configuration register file.
    typedef struct packed {
        t_radix     radix_mode;
        logic       sign_allowed;
        logic       width_given;
        logic [11:0] max_width;
        logic       short_result;
    } t_cfg;

    // Numeric radix for a radix code; automatic has no digits of its own.
    function automatic logic [4:0] radix_value(input t_radix r);
        logic [4:0] v;
        case (r)
            RADIX_OCT: v = 5'd8;
            RADIX_DEC: v = 5'd10;
            RADIX_HEX: v = 5'd16;
            default:   v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/itfp_fifo.sv @@
module itfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    // Handshake qualification.
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/itfp_front.sv @@
module itfp_front (
    input  itfp_pkg::t_char_in i_char_in,
    output itfp_pkg::t_cls     o_cls
);
    import itfp_pkg::*;

    logic [7:0] c;
    logic       live;
    logic       is_dec;
    logic       is_lc;
    logic       is_uc;
    logic [7:0] dval;

    assign c    = i_char_in.char_code;
    assign live = !i_char_in.end_of_input;

    // Digit value over 0-9, a-z and A-Z; the radix check is left to the back end.
    always_comb begin
        is_dec = (c >= CH_0) && (c <= CH_9);
        is_lc  = (c >= CH_LC_A) && (c <= CH_LC_Z);
        is_uc  = (c >= CH_UC_A) && (c <= CH_UC_Z);
        if (is_dec) begin
            dval = c - CH_0;
        end else if (is_lc) begin
            dval = c - CH_LC_A + LETTER_BASE;
        end else begin
            dval = c - CH_UC_A + LETTER_BASE;
        end
    end

    // Character classes; an end-of-input word matches nothing.
    always_comb begin
        o_cls.eof         = !live;
        o_cls.is_space    = live && ((c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)));
        o_cls.is_plus     = live && (c == CH_PLUS);
        o_cls.is_minus    = live && (c == CH_MINUS);
        o_cls.is_zero     = live && (c == CH_0);
        o_cls.is_x        = live && ((c == CH_LC_X) || (c == CH_UC_X));
        o_cls.digit_valid = live && (is_dec || is_lc || is_uc);
        o_cls.digit_val   = dval[5:0];
    end

endmodule

@@ hw/rtl/itfp_back.sv @@
`include "integer_text_field_parser_core_defines.svh"

module itfp_back #(
    parameter int VALUE_BITS = itfp_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itfp_pkg::t_cfg    i_cfg,
    input  logic              i_cls_valid,
    input  itfp_pkg::t_cls    i_cls,
    output logic              o_cls_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output itfp_pkg::t_result o_result
);
    import itfp_pkg::*;

    localparam int VB = VALUE_BITS;

    // Field state.
    t_phase         r_phase, n_phase;
    logic [VB-1:0]  r_acc, n_acc;
    logic [11:0]    r_wl, n_wl;
    logic           r_unl, n_unl;
    t_radix         r_radix, n_radix;
    logic           r_neg, n_neg;
    logic           r_ok, n_ok;
    logic [15:0]    r_count, n_count;

    // Effective state for this word, with the field start folded in.
    logic           f_start;
    t_phase         fp;
    logic [VB-1:0]  f_acc;
    logic [11:0]    f_wl;
    logic           f_unl;
    t_radix         f_radix;
    logic           f_neg;
    logic           f_ok;
    logic           room;
    t_radix         d_radix;
    logic           digit_hit;
    t_act           act;

    logic           fire;
    logic           emit;
    logic           take;
    logic [VB-1:0]  acc_mac;
    logic [VB-1:0]  signed_val;
    logic [VB-1:0]  res_val;
    logic [VB+31:0] res_ext;

    assign fire      = i_cls_valid && !i_res_full;
    assign o_cls_pop = fire;

    // Decode: pick the action for the word at the head of the queue.
    always_comb begin
        f_start = (r_phase == PH_SKIP) && !i_cls.eof && !i_cls.is_space;
        if (f_start) begin
            fp      = PH_ZERO;
            f_acc   = '0;
            f_wl    = i_cfg.max_width;
            f_unl   = !i_cfg.width_given;
            f_radix = i_cfg.radix_mode;
            f_neg   = 1'b0;
            f_ok    = 1'b0;
        end else begin
            fp      = r_phase;
            f_acc   = r_acc;
            f_wl    = r_wl;
            f_unl   = r_unl;
            f_radix = r_radix;
            f_neg   = r_neg;
            f_ok    = r_ok;
        end
        room = f_unl || (f_wl != 12'd0);

        // An unresolved automatic radix becomes decimal or octal here.
        d_radix = f_radix;
        if (f_radix == RADIX_AUTO && fp == PH_ZERO) begin
            d_radix = RADIX_DEC;
        end else if (f_radix == RADIX_AUTO && fp == PH_PREFIX) begin
            d_radix = RADIX_OCT;
        end
        digit_hit = room && i_cls.digit_valid &&
                    (i_cls.digit_val < {1'b0, radix_value(d_radix)});

        if (r_phase == PH_SKIP && i_cls.eof) begin
            act = ACT_EMPTY;
        end else if (r_phase == PH_SKIP && i_cls.is_space) begin
            act = ACT_SPACE;
        end else if (f_start && room && i_cfg.sign_allowed &&
                     (i_cls.is_plus || i_cls.is_minus)) begin
            act = ACT_SIGN;
        end else if (fp == PH_ZERO && room && i_cls.is_zero) begin
            act = ACT_ZERO;
        end else if (fp == PH_PREFIX && room && i_cls.is_x &&
                     (f_radix == RADIX_AUTO || f_radix == RADIX_HEX)) begin
            act = ACT_X;
        end else if (digit_hit) begin
            act = ACT_DIGIT;
        end else begin
            act = ACT_END;
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (fire) begin
            case (act)
                ACT_SIGN:  n_phase = PH_ZERO;
                ACT_ZERO:  n_phase = PH_PREFIX;
                ACT_X:     n_phase = PH_DIGITS;
                ACT_DIGIT: n_phase = PH_DIGITS;
                default:   n_phase = PH_SKIP;
            endcase
        end
    end

    // Accumulate one digit: multiply by 8, 10 or 16 as shifts and adds, then add the digit.
    always_comb begin
        case (d_radix)
            RADIX_OCT: acc_mac = (f_acc << 3) + VB'(i_cls.digit_val);
            RADIX_DEC: acc_mac = (f_acc << 3) + (f_acc << 1) + VB'(i_cls.digit_val);
            RADIX_HEX: acc_mac = (f_acc << 4) + VB'(i_cls.digit_val);
            default:   acc_mac = '0;
        endcase
    end

    // Field registers and the result word.
    always_comb begin
        take = (act == ACT_SIGN) || (act == ACT_ZERO) ||
               (act == ACT_X) || (act == ACT_DIGIT);
        emit = (act == ACT_EMPTY) || (act == ACT_END);

        n_acc   = f_acc;
        n_wl    = f_wl;
        n_unl   = f_unl;
        n_radix = f_radix;
        n_neg   = f_neg;
        n_ok    = f_ok;
        n_count = r_count;

        if (take && !f_unl && f_wl != 12'd0) begin
            n_wl = f_wl - 12'd1;
        end
        if (take || act == ACT_SPACE) begin
            n_count = (r_count != 16'hFFFF) ? r_count + 16'd1 : r_count;
        end
        if (emit) begin
            n_count = '0;
        end

        case (act)
            ACT_SIGN: begin
                n_neg = i_cls.is_minus;
            end
            ACT_ZERO: begin
                n_ok = 1'b1;
            end
            ACT_X: begin
                n_ok    = 1'b0;
                n_radix = RADIX_HEX;
            end
            ACT_DIGIT: begin
                n_ok    = 1'b1;
                n_radix = d_radix;
                n_acc   = acc_mac;
            end
            default: begin
            end
        endcase

        // Negate, then optionally keep the low half-word.
        signed_val = f_neg ? (VB'(0) - f_acc) : f_acc;
        res_val    = i_cfg.short_result ? (signed_val & VB'(32'h0000_FFFF)) : signed_val;
        if (act == ACT_EMPTY || !f_ok) begin
            res_val = '0;
        end
        res_ext = {32'd0, res_val};

        o_result.value          = res_ext[31:0];
        o_result.chars_consumed = r_count;
        o_result.char_taken     = 1'b0;
        if (act == ACT_EMPTY) begin
            o_result.status = ST_EMPTY_INPUT;
        end else if (f_ok) begin
            o_result.status = ST_CONVERTED;
        end else begin
            o_result.status = ST_NO_DIGITS;
        end
        o_res_push = fire && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_count <= '0;
            r_wl    <= '0;
            r_unl   <= 1'b0;
            r_radix <= RADIX_AUTO;
            r_neg   <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (fire) begin
                r_count <= n_count;
                r_wl    <= n_wl;
                r_unl   <= n_unl;
                r_radix <= n_radix;
                r_neg   <= n_neg;
                r_ok    <= n_ok;
            end
        end
    end

    // Accumulator is payload.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_acc <= n_acc;
        end
    end

    // Reset leaves the back end waiting for a new field.
    `ITFP_ASSERT_RST(a_reset_idle, (!i_rst_n) |=> (r_phase == PH_SKIP && r_count == '0), "back end not idle after reset")
    // Digits are only gathered once the radix is resolved.
    `ITFP_ASSERT(a_digits_radix, (r_phase == PH_DIGITS) |-> (r_radix != RADIX_AUTO), "digit phase with unresolved radix")
    // A limited width never goes below zero.
    `ITFP_ASSERT(a_width_floor, (fire && take && !f_unl) |-> (f_wl != 12'd0), "character taken with no width left")
    // The consumed count only falls when a result leaves.
    `ITFP_ASSERT(a_count_mono, (fire && !emit) |=> (r_count >= $past(r_count)), "consumed count fell mid field")
    // Every result starts a fresh count.
    `ITFP_ASSERT(a_count_clear, (fire && emit) |=> (r_count == '0 && r_phase == PH_SKIP), "field state kept after result")

endmodule

@@ hw/rtl/integer_text_field_parser_core.sv @@
// Channel  | Handshake        | Word                    | Direction
// ---------+------------------+-------------------------+----------
// input    | push / full      | i_char_in (t_char_in)   | in
// result   | empty / pop      | o_result (t_result)     | out
// config   | valid / ready    | i_cfg_index, i_cfg_data | in
//
// One character is taken per cycle, sustained while the result queue is not full;
// the digit multiply-add by 8, 10 or 16 in the back end is combinational.
// A result is pushed into the result queue in the same cycle as its ending character is taken.
// Reset is synchronous and active low; it empties both queues, clears the field
// state and loads the register defaults. No clearing pass is needed.
// full rises only when the character queue fills because the result queue is full.
module integer_text_field_parser_core #(
    parameter int VALUE_BITS  = itfp_pkg::VALUE_BITS_DEF,
    parameter int QUEUE_DEPTH = itfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  itfp_pkg::t_char_in                  i_char_in,
    output logic                                empty,
    input  logic                                pop,
    output itfp_pkg::t_result                   o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [itfp_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [itfp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import itfp_pkg::*;

    localparam int CLS_W = $bits(t_cls);
    localparam int RES_W = $bits(t_result);

    t_cfg             r_cfg;
    t_cls             front_cls;
    logic [CLS_W-1:0] mid_data;
    logic             mid_empty;
    logic             cls_pop;
    logic             res_full;
    logic             res_push;
    t_result          back_result;
    logic [RES_W-1:0] out_data;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix_mode   <= RADIX_DEC;
            r_cfg.sign_allowed <= 1'b1;
            r_cfg.width_given  <= 1'b0;
            r_cfg.max_width    <= '0;
            r_cfg.short_result <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RADIX_MODE:   r_cfg.radix_mode   <= t_radix'(i_cfg_data[1:0]);
                CFG_SIGN_ALLOWED: r_cfg.sign_allowed <= i_cfg_data[0];
                CFG_WIDTH_GIVEN:  r_cfg.width_given  <= i_cfg_data[0];
                CFG_MAX_WIDTH:    r_cfg.max_width    <= i_cfg_data[11:0];
                CFG_SHORT_RESULT: r_cfg.short_result <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Front end: classify each character.
    itfp_front u_front (
        .i_char_in (i_char_in),
        .o_cls     (front_cls)
    );

    // Queue between classifier and parser.
    itfp_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (full),
        .i_pop   (cls_pop),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    // Back end: field state machine and accumulator.
    itfp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cls_valid (!mid_empty),
        .i_cls       (t_cls'(mid_data)),
        .o_cls_pop   (cls_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_result    (back_result)
    );

    // Result queue seen by the consumer.
    itfp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign o_result = t_result'(out_data);

endmodule
